@@ hw/rtl/iir_df1_pkg.sv @@
`timescale 1ns / 1ps

package iir_df1_pkg;

  localparam int SMP_W      = 16;
  localparam int COEF_W     = 32;
  localparam int ORD_W      = 5;
  localparam int IDX_W      = 5;
  localparam int MAX_ORDER  = 16;
  localparam int HIST_DEPTH = 32;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int COEF_DEPTH = MAX_ORDER + 1;
  localparam int TAP_W      = $clog2(COEF_DEPTH);
  localparam int PROD_W     = COEF_W + SMP_W;
  localparam int ACC_W      = PROD_W + $clog2(2 * MAX_ORDER + 1);

  // Q15.39 sum -> Q1.15: bits [Y_MSB:FRAC_SHIFT] after adding half an LSB
  localparam int FRAC_SHIFT = 24;
  localparam int Y_MSB      = FRAC_SHIFT + SMP_W - 1;

  localparam logic signed [ACC_W-1:0]  ROUND_HALF = ACC_W'(64'sd1 <<< (FRAC_SHIFT - 1));
  localparam logic signed [COEF_W-1:0] A0_RESET   = COEF_W'(64'sd1 <<< FRAC_SHIFT);
  localparam logic signed [SMP_W-1:0]  SMP_MAX    = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0]  SMP_MIN    = {1'b1, {(SMP_W-1){1'b0}}};

  // opcodes
  localparam logic [1:0] OP_SAMPLE  = 2'd0;
  localparam logic [1:0] OP_FILL    = 2'd1;
  localparam logic [1:0] OP_COEF_WR = 2'd2;

  // config port
  localparam int         CFG_AW           = 3;
  localparam int         CFG_DW           = 32;
  localparam logic [0:0] REG_FILTER_ORDER = 1'b0;

  typedef logic [HIST_AW-1:0] hist_addr_t;
  typedef logic [TAP_W-1:0]   tap_t;

  typedef struct packed {
    logic [1:0]              opcode;
    logic signed [SMP_W-1:0] sample_value;
    logic                    coef_bank;
    logic [IDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;
  } in_item_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] filtered_sample;
    logic                    saturated;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN1,
    ST_DRAIN2,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic hist_fill;
    logic coef_wr;
    logic smp_start;
    logic term_vld;
    logic term_bank;   // 0: a*x, 1: b*y
    tap_t term_tap;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

@@ hw/rtl/iir_filter_direct_form_one_top.sv @@
`timescale 1ns / 1ps

// Channel  Dir  Handshake            Payload
// in       in   in_valid / in_stall  in_data  (opcode, sample, coef bank/index/value)
// out      out  out_valid / out_stall out_data (filtered_sample, saturated)
// cfg      in   APB, pready high     filter_order at byte address 0
//
// A sample beat runs 2*order+1 products (order capped at 16) through one
// multiply-accumulate unit, then drain states ST_DRAIN1, ST_DRAIN2 and round ST_FIN.
// Fill, coefficient-write and unused beats are taken in the idle state and give no result.
// The result register frees the input side; a stalled result holds the next
// sample in its round cycle until out_stall drops.
// Synchronous reset; no clearing pass, history and coefficients read as reset
// values through per-entry valid bits.

module iir_filter_direct_form_one_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  iir_df1_pkg::in_item_t               in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output iir_df1_pkg::out_item_t              out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [iir_df1_pkg::CFG_AW-1:0]      cfg_paddr,
  input  logic [iir_df1_pkg::CFG_DW-1:0]      cfg_pwdata,
  output logic [iir_df1_pkg::CFG_DW-1:0]      cfg_prdata,
  output logic                                cfg_pready
);

  logic [iir_df1_pkg::ORD_W-1:0] order_r;
  logic [0:0]                    reg_idx;
  logic                          cfg_wr;
  iir_df1_pkg::cmd_t             cmd;
  iir_df1_pkg::sts_t             sts;

  assign reg_idx    = cfg_paddr[iir_df1_pkg::CFG_AW-1:2];
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (reg_idx == iir_df1_pkg::REG_FILTER_ORDER) ?
                      iir_df1_pkg::CFG_DW'(order_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= '0;
    end else if (cfg_wr && (reg_idx == iir_df1_pkg::REG_FILTER_ORDER)) begin
      order_r <= cfg_pwdata[iir_df1_pkg::ORD_W-1:0];
    end
  end

  iir_df1_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .opcode       (in_data.opcode),
    .filter_order (order_r),
    .sts          (sts),
    .in_stall     (in_stall),
    .cmd          (cmd)
  );

  iir_df1_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ hw/rtl/iir_df1_ctrl.sv @@
`timescale 1ns / 1ps

module iir_df1_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic [1:0]                      opcode,
  input  logic [iir_df1_pkg::ORD_W-1:0]   filter_order,
  input  iir_df1_pkg::sts_t               sts,
  output logic                            in_stall,
  output iir_df1_pkg::cmd_t               cmd
);

  iir_df1_pkg::state_t state_r, state_nxt;
  iir_df1_pkg::tap_t   tap_r, tap_nxt;
  logic                bank_r, bank_nxt;
  iir_df1_pkg::tap_t   ord;
  logic                accept;
  logic                last_term;

  assign ord = (filter_order > iir_df1_pkg::ORD_W'(iir_df1_pkg::MAX_ORDER)) ?
               iir_df1_pkg::TAP_W'(iir_df1_pkg::MAX_ORDER) :
               iir_df1_pkg::TAP_W'(filter_order);

  assign in_stall  = (state_r != iir_df1_pkg::ST_IDLE);
  assign accept    = in_valid && !in_stall;
  // tap 0 has only the feedforward term
  assign last_term = (tap_r == ord) && (bank_r || (tap_r == '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iir_df1_pkg::ST_IDLE;
      tap_r   <= '0;
      bank_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tap_r   <= tap_nxt;
      bank_r  <= bank_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    tap_nxt       = tap_r;
    bank_nxt      = bank_r;
    cmd           = '0;
    cmd.term_tap  = tap_r;
    cmd.term_bank = bank_r;
    unique case (state_r)
      iir_df1_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            iir_df1_pkg::OP_SAMPLE: begin
              cmd.smp_start = 1'b1;
              tap_nxt       = '0;
              bank_nxt      = 1'b0;
              state_nxt     = iir_df1_pkg::ST_RUN;
            end
            iir_df1_pkg::OP_FILL:    cmd.hist_fill = 1'b1;
            iir_df1_pkg::OP_COEF_WR: cmd.coef_wr   = 1'b1;
            default: ;
          endcase
        end
      end
      iir_df1_pkg::ST_RUN: begin
        cmd.term_vld = 1'b1;
        if (last_term) begin
          state_nxt = iir_df1_pkg::ST_DRAIN1;
        end else if (!bank_r && (tap_r != '0)) begin
          bank_nxt = 1'b1;
        end else begin
          tap_nxt  = tap_r + 1'b1;
          bank_nxt = 1'b0;
        end
      end
      // read and multiply stages empty out
      iir_df1_pkg::ST_DRAIN1: state_nxt = iir_df1_pkg::ST_DRAIN2;
      iir_df1_pkg::ST_DRAIN2: state_nxt = iir_df1_pkg::ST_FIN;
      iir_df1_pkg::ST_FIN: begin
        if (!sts.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt  = iir_df1_pkg::ST_IDLE;
        end
      end
      default: state_nxt = iir_df1_pkg::ST_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/iir_df1_dp.sv @@
`timescale 1ns / 1ps

module iir_df1_dp (
  input  logic                   clk,
  input  logic                   rst_n,
  input  iir_df1_pkg::in_item_t  in_data,
  input  iir_df1_pkg::cmd_t      cmd,
  output iir_df1_pkg::sts_t      sts,
  input  logic                   out_stall,
  output logic                   out_valid,
  output iir_df1_pkg::out_item_t out_data
);

  localparam int SW = iir_df1_pkg::SMP_W;
  localparam int CW = iir_df1_pkg::COEF_W;
  localparam int PW = iir_df1_pkg::PROD_W;
  localparam int AW = iir_df1_pkg::ACC_W;
  localparam int HD = iir_df1_pkg::HIST_DEPTH;
  localparam int CD = iir_df1_pkg::COEF_DEPTH;

  // history and coefficient stores
  logic signed [SW-1:0] x_mem [HD];
  logic signed [SW-1:0] y_mem [HD];
  logic signed [CW-1:0] a_mem [CD];
  logic signed [CW-1:0] b_mem [CD];

  // entries not yet written read as fill value / reset coefficient
  logic [HD-1:0]            x_vld_r, y_vld_r;
  logic [CD-1:0]            a_vld_r, b_vld_r;
  logic signed [SW-1:0]     fill_r;
  iir_df1_pkg::hist_addr_t  pos_r;
  iir_df1_pkg::hist_addr_t  rd_addr;

  logic                     coef_ok;
  iir_df1_pkg::tap_t        wr_idx;

  // read stage
  logic                     t1_vld_r, t1_bank_r, t1_tap0_r;
  logic                     t1_xv_r, t1_yv_r, t1_av_r, t1_bv_r;
  logic signed [SW-1:0]     x_rd_r, y_rd_r;
  logic signed [CW-1:0]     a_rd_r, b_rd_r;
  logic signed [SW-1:0]     hist_op;
  logic signed [CW-1:0]     coef_op;

  // multiply and accumulate
  logic signed [PW-1:0]     prod_nxt, prod_r;
  logic                     p_vld_r;
  logic signed [AW-1:0]     acc_r;

  // round and saturate
  logic signed [AW-1:0]            rnd;
  logic [AW-1:iir_df1_pkg::Y_MSB]  rnd_hi;
  logic                            in_range;
  logic signed [SW-1:0]            y_res;

  logic                   out_valid_r;
  iir_df1_pkg::out_item_t out_data_r;

  assign rd_addr = pos_r - iir_df1_pkg::hist_addr_t'(cmd.term_tap);
  assign wr_idx  = iir_df1_pkg::TAP_W'(in_data.coef_index);
  assign coef_ok = (32'(in_data.coef_index) <= 32'(iir_df1_pkg::MAX_ORDER));

  always_ff @(posedge clk) begin
    if (cmd.smp_start) begin
      x_mem[pos_r] <= in_data.sample_value;
    end
    if (cmd.finish) begin
      y_mem[pos_r] <= y_res;
    end
    x_rd_r <= x_mem[rd_addr];
    y_rd_r <= y_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.coef_wr && coef_ok) begin
      if (in_data.coef_bank) begin
        b_mem[wr_idx] <= in_data.coef_value;
      end else begin
        a_mem[wr_idx] <= in_data.coef_value;
      end
    end
    a_rd_r <= a_mem[cmd.term_tap];
    b_rd_r <= b_mem[cmd.term_tap];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_vld_r <= '0;
      y_vld_r <= '0;
      a_vld_r <= '0;
      b_vld_r <= '0;
      fill_r  <= '0;
      pos_r   <= '0;
    end else begin
      if (cmd.hist_fill) begin
        x_vld_r <= '0;
        y_vld_r <= '0;
        fill_r  <= in_data.sample_value;
        pos_r   <= '0;
      end
      if (cmd.smp_start) begin
        x_vld_r[pos_r] <= 1'b1;
      end
      if (cmd.finish) begin
        y_vld_r[pos_r] <= 1'b1;
        pos_r          <= pos_r + 1'b1;
      end
      if (cmd.coef_wr && coef_ok) begin
        if (in_data.coef_bank) begin
          b_vld_r[wr_idx] <= 1'b1;
        end else begin
          a_vld_r[wr_idx] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t1_vld_r <= 1'b0;
      p_vld_r  <= 1'b0;
    end else begin
      t1_vld_r <= cmd.term_vld;
      p_vld_r  <= t1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    t1_bank_r <= cmd.term_bank;
    t1_tap0_r <= (cmd.term_tap == '0);
    t1_xv_r   <= x_vld_r[rd_addr];
    t1_yv_r   <= y_vld_r[rd_addr];
    t1_av_r   <= a_vld_r[cmd.term_tap];
    t1_bv_r   <= b_vld_r[cmd.term_tap];
  end

  always_comb begin
    if (t1_bank_r) begin
      hist_op = t1_yv_r ? y_rd_r : fill_r;
      coef_op = t1_bv_r ? b_rd_r : '0;
    end else begin
      hist_op = t1_xv_r ? x_rd_r : fill_r;
      if (t1_av_r) begin
        coef_op = a_rd_r;
      end else begin
        coef_op = t1_tap0_r ? iir_df1_pkg::A0_RESET : '0;
      end
    end
  end

  assign prod_nxt = coef_op * hist_op;

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (cmd.smp_start) begin
      acc_r <= '0;
    end else if (p_vld_r) begin
      acc_r <= acc_r + {{(AW-PW){prod_r[PW-1]}}, prod_r};
    end
  end

  assign rnd      = acc_r + iir_df1_pkg::ROUND_HALF;
  assign rnd_hi   = rnd[AW-1:iir_df1_pkg::Y_MSB];
  assign in_range = (&rnd_hi) || !(|rnd_hi);
  assign y_res    = in_range ? rnd[iir_df1_pkg::Y_MSB:iir_df1_pkg::FRAC_SHIFT] :
                    (rnd[AW-1] ? iir_df1_pkg::SMP_MIN : iir_df1_pkg::SMP_MAX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_data_r.filtered_sample <= y_res;
      out_data_r.saturated       <= !in_range;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data     = out_data_r;
  assign sts.out_busy = out_valid_r && out_stall;

endmodule

@@ bench/iir_filter_direct_form_one_top_tb.sv @@
`timescale 1ns / 1ps

module iir_filter_direct_form_one_top_tb;
  import iir_df1_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         REG_SPARE    = 1;      // decodes to nothing
  localparam longint     ROUND_BIAS   = 64'sd1 <<< (FRAC_SHIFT - 1);
  localparam longint     SUM_LIM      = 64'sd1 <<< (FRAC_SHIFT + SMP_W - 1);
  localparam int         DRAIN_CYCLES = 50;
  localparam int         QUIET_LIMIT  = 5000;
  localparam int         HOLD_CYCLES  = 400;
  localparam int         BEATS_PER_PH = 104;
  localparam int         NUM_PHASES   = 8;

  class iir_scoreboard;
    logic signed [SMP_W-1:0]  x_hist [HIST_DEPTH];
    logic signed [SMP_W-1:0]  y_hist [HIST_DEPTH];
    logic signed [COEF_W-1:0] a_coef [COEF_DEPTH];
    logic signed [COEF_W-1:0] b_coef [COEF_DEPTH];
    int unsigned              wr_pos;
    int unsigned              order_reg;
    out_item_t                filtered_q [$];
    int                       n_bad;

    function new();
      foreach (x_hist[i]) begin
        x_hist[i] = '0;
        y_hist[i] = '0;
      end
      foreach (a_coef[i]) begin
        a_coef[i] = '0;
        b_coef[i] = '0;
      end
      a_coef[0] = A0_RESET;
      wr_pos    = 0;
      order_reg = 0;
      n_bad     = 0;
    endfunction

    function void write_order(int idx, logic [CFG_DW-1:0] val);
      if (idx == REG_FILTER_ORDER) order_reg = 32'(val[ORD_W-1:0]);
    endfunction

    function void note_input(in_item_t beat);
      longint      acc;
      longint      rnd;
      int unsigned taps;
      int unsigned p;
      int unsigned k;
      out_item_t   res;
      case (beat.opcode)
        OP_FILL: begin
          foreach (x_hist[i]) begin
            x_hist[i] = beat.sample_value;
            y_hist[i] = beat.sample_value;
          end
          wr_pos = 0;
        end
        OP_COEF_WR: begin
          // taps past MAX_ORDER are dropped; b[0] is kept but never used
          if (beat.coef_index <= MAX_ORDER) begin
            if (beat.coef_bank) b_coef[beat.coef_index] = beat.coef_value;
            else a_coef[beat.coef_index] = beat.coef_value;
          end
        end
        OP_SAMPLE: begin
          taps = (order_reg > MAX_ORDER) ? MAX_ORDER : order_reg;
          x_hist[wr_pos] = beat.sample_value;
          acc = longint'(a_coef[0]) * longint'(beat.sample_value);
          for (k = 1; k <= taps; k++) begin
            p = (wr_pos + HIST_DEPTH - (k % HIST_DEPTH)) % HIST_DEPTH;
            acc += longint'(a_coef[k]) * longint'(x_hist[p]);
            acc += longint'(b_coef[k]) * longint'(y_hist[p]);
          end
          // round half up, then clamp to Q1.15
          rnd = acc + ROUND_BIAS;
          if (rnd >= SUM_LIM) begin
            res.filtered_sample = SMP_MAX;
            res.saturated       = 1'b1;
          end else if (rnd < -SUM_LIM) begin
            res.filtered_sample = SMP_MIN;
            res.saturated       = 1'b1;
          end else begin
            res.filtered_sample = SMP_W'(rnd >>> FRAC_SHIFT);
            res.saturated       = 1'b0;
          end
          y_hist[wr_pos] = res.filtered_sample;
          wr_pos = (wr_pos + 1) % HIST_DEPTH;
          filtered_q.push_back(res);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (filtered_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result beat: sample %0d sat %0d",
                   got.filtered_sample, got.saturated);
      end else begin
        want = filtered_q.pop_front();
        if (got.filtered_sample !== want.filtered_sample ||
            got.saturated !== want.saturated) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch at %0t: sample exp %0d got %0d, sat exp %0d got %0d",
                     $realtime, want.filtered_sample, got.filtered_sample,
                     want.saturated, got.saturated);
        end
      end
    endfunction
  endclass

  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_stall;
  in_item_t          in_data     = '0;
  logic              out_valid;
  logic              out_stall   = 1'b0;
  out_item_t         out_data;
  logic              cfg_psel    = 1'b0;
  logic              cfg_penable = 1'b0;
  logic              cfg_pwrite  = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr   = '0;
  logic [CFG_DW-1:0] cfg_pwdata  = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  iir_scoreboard sb = new();

  int snd_idle_pct  = 0;
  int rcv_stall_pct = 0;
  int hold_req_n    = 0;
  int hold_seen     = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  iir_filter_direct_form_one_top u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk) begin
    if (hold_seen != hold_req_n) begin
      hold_seen = hold_req_n;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rcv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_input(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("no beat for %0d cycles", QUIET_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  function automatic in_item_t make_beat(logic [1:0] op, logic signed [SMP_W-1:0] smp,
                                         logic bank, logic [IDX_W-1:0] idx,
                                         logic signed [COEF_W-1:0] coef);
    in_item_t beat;
    beat.opcode       = op;
    beat.sample_value = smp;
    beat.coef_bank    = bank;
    beat.coef_index   = idx;
    beat.coef_value   = coef;
    return beat;
  endfunction

  function automatic in_item_t rand_beat();
    in_item_t beat;
    int       roll;
    roll = $urandom_range(99);
    if (roll < 72) beat.opcode = OP_SAMPLE;
    else if (roll < 90) beat.opcode = OP_COEF_WR;
    else if (roll < 96) beat.opcode = OP_FILL;
    else beat.opcode = OP_UNUSED;
    case ($urandom_range(9))
      0:       beat.sample_value = SMP_MAX;
      1:       beat.sample_value = SMP_MIN;
      2:       beat.sample_value = SMP_W'(int'($urandom_range(255)) - 128);
      default: beat.sample_value = SMP_W'($urandom);
    endcase
    beat.coef_bank  = 1'($urandom_range(1));
    beat.coef_index = ($urandom_range(9) == 0) ? IDX_W'($urandom) :
                                                 IDX_W'($urandom_range(MAX_ORDER));
    // mostly small taps keep the loop from pinning at the rails
    case ($urandom_range(9))
      0:       beat.coef_value = $urandom;
      1, 2:    beat.coef_value = int'($urandom_range(1 << 26)) - (1 << 25);
      default: beat.coef_value = int'($urandom_range(1 << 21)) - (1 << 20);
    endcase
    return beat;
  endfunction

  task automatic send_item(input in_item_t beat);
    while ($urandom_range(99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic cfg_write(input int idx, input logic [ORD_W-1:0] val);
    logic [CFG_DW-1:0] word;
    // upper bits are junk; only the low field is kept
    word = {(CFG_DW - ORD_W)'($urandom), val};
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= CFG_AW'(4 * idx);
    cfg_pwdata  <= word;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.write_order(idx, word);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // fill and coefficient beats give no result, so allow a full sample time
  task automatic wait_drained();
    do @(posedge clk); while (sb.filtered_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int               ph;
    int               n;
    logic [ORD_W-1:0] order_list [NUM_PHASES];

    order_list = '{5'd1, 5'd16, 5'd31, 5'd2, 5'd17, 5'd8, 5'd0,
                   ORD_W'($urandom_range(31))};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: identity path, rails, rounding, ignored writes, fills
    cfg_write(REG_SPARE, 5'd4);
    send_item(make_beat(OP_SAMPLE, SMP_MAX, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_SAMPLE, SMP_MIN, 1'b1, 5'd31, -32'sd1));
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b0, 5'd0, 32'sh7fff_ffff));
    send_item(make_beat(OP_SAMPLE, SMP_MAX, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_SAMPLE, SMP_MIN, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b0, 5'd0, 32'sh8000_0000));
    send_item(make_beat(OP_SAMPLE, SMP_MIN, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b0, 5'd0, 32'sh0080_0000));
    send_item(make_beat(OP_SAMPLE, 16'sd1, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_SAMPLE, -16'sd1, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b1, 5'd0, 32'sh7fff_ffff));
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b0, 5'd17, 32'sh0100_0000));
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b1, 5'd31, 32'sh8000_0000));
    send_item(make_beat(OP_UNUSED, SMP_MAX, 1'b1, 5'd31, -32'sd1));
    send_item(make_beat(OP_FILL, SMP_MIN, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b0, 5'd0, A0_RESET));
    send_item(make_beat(OP_SAMPLE, 16'sd0, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_FILL, SMP_MAX, 1'b0, 5'd0, 32'sd0));
    in_valid <= 1'b0;
    wait_drained();

    cfg_write(REG_FILTER_ORDER, 5'd16);
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b0, 5'd16, A0_RESET));
    send_item(make_beat(OP_COEF_WR, 16'sd0, 1'b1, 5'd16, 32'sh0080_0000));
    send_item(make_beat(OP_SAMPLE, 16'sd0, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_SAMPLE, 16'sd100, 1'b0, 5'd0, 32'sd0));
    send_item(make_beat(OP_FILL, 16'sd0, 1'b0, 5'd0, 32'sd0));
    in_valid <= 1'b0;

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      cfg_write(REG_FILTER_ORDER, order_list[ph]);
      case (ph % 4)
        0: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 0;
        end
        1: begin
          snd_idle_pct  = 72;
          rcv_stall_pct = 0;
        end
        2: begin
          snd_idle_pct  = 0;
          rcv_stall_pct = 72;
        end
        default: begin
          snd_idle_pct  = 11;
          rcv_stall_pct = 11;
        end
      endcase
      // back up the result side while the sender keeps pushing
      if (ph == 4) hold_req_n++;
      for (n = 0; n < BEATS_PER_PH; n++) send_item(rand_beat());
      in_valid <= 1'b0;
    end

    wait_drained();
    if (sb.n_bad == 0 && sb.filtered_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
hw/rtl/iir_df1_pkg.sv
hw/rtl/iir_df1_ctrl.sv
hw/rtl/iir_df1_dp.sv
hw/rtl/iir_filter_direct_form_one_top.sv
bench/iir_filter_direct_form_one_top_tb.sv
